@@ rtl/core/wsfd_pkg.sv @@
package wsfd_pkg;

	localparam int unsigned LEN_W  = 64;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned IDX_W  = 4;
	localparam int unsigned HDR_W  = 4;

	localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 64'd65536;

	localparam logic [6:0]       LEN7_MASK  = 7'h7f;
	localparam logic [6:0]       LEN_CODE16 = 7'd126;
	localparam logic [6:0]       LEN_CODE64 = 7'd127;
	localparam int unsigned      MASK_BIT   = 7;
	localparam logic [IDX_W-1:0] KEY_BYTES  = 4'd4;

	localparam logic [HDR_W-1:0] HDR_SIZE_BASE = 4'd2;
	localparam logic [HDR_W-1:0] HDR_SIZE_16   = 4'd4;
	localparam logic [HDR_W-1:0] HDR_SIZE_64   = 4'd10;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_MASK,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [1:0] {
		PART_HDR     = 2'd0,
		PART_EXT     = 2'd1,
		PART_MASK    = 2'd2,
		PART_PAYLOAD = 2'd3
	} part_t;

	typedef struct packed {
		part_t            part;
		logic             frame_end;
		logic             oversize;
		logic [LEN_W-1:0] total;
	} res_t;

endpackage

@@ rtl/core/wsfd_parser.sv @@
module wsfd_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [wsfd_pkg::BYTE_W-1:0]      data_in,
	input  logic [wsfd_pkg::LEN_W-1:0]       size_limit,
	output wsfd_pkg::res_t                   res
);

	wsfd_pkg::phase_t               phase_q, phase_n;
	logic [wsfd_pkg::IDX_W-1:0]     idx_q, idx_n;
	logic                           masked_q, masked_n;
	logic [wsfd_pkg::LEN_W-1:0]     len_q, len_n;
	logic [wsfd_pkg::LEN_W-1:0]     remain_q, remain_n;
	logic [wsfd_pkg::HDR_W-1:0]     hdr_q, hdr_n;
	logic                           err_q, err_n;
	logic [wsfd_pkg::LEN_W-1:0]     total_q, total_n;

	logic [6:0]                     len7;
	logic [wsfd_pkg::LEN_W-1:0]     rem_dec;
	logic [wsfd_pkg::HDR_W:0]       fixed;
	logic [wsfd_pkg::LEN_W:0]       sum;
	logic [wsfd_pkg::LEN_W-1:0]     total_c;
	logic                           len_done;
	logic                           pay_or_end;
	logic                           end_c;
	wsfd_pkg::part_t                part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsfd_pkg::PH_HDR0;
			idx_q    <= '0;
			masked_q <= 1'b0;
			len_q    <= '0;
			remain_q <= '0;
			hdr_q    <= '0;
			err_q    <= 1'b0;
			total_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			masked_q <= masked_n;
			len_q    <= len_n;
			remain_q <= remain_n;
			hdr_q    <= hdr_n;
			err_q    <= err_n;
			total_q  <= total_n;
		end
	end

	always_comb begin
		phase_n    = phase_q;
		idx_n      = idx_q;
		masked_n   = masked_q;
		len_n      = len_q;
		remain_n   = remain_q;
		hdr_n      = hdr_q;
		err_n      = err_q;
		total_n    = total_q;
		part       = wsfd_pkg::PART_HDR;
		len_done   = 1'b0;
		pay_or_end = 1'b0;
		end_c      = 1'b0;
		len7       = data_in[6:0] & wsfd_pkg::LEN7_MASK;
		rem_dec    = '0;
		case (phase_q)
			wsfd_pkg::PH_HDR0: begin
				phase_n = wsfd_pkg::PH_HDR1;
			end
			wsfd_pkg::PH_HDR1: begin
				masked_n = data_in[wsfd_pkg::MASK_BIT];
				idx_n    = '0;
				if (len7 == wsfd_pkg::LEN_CODE16) begin
					hdr_n   = wsfd_pkg::HDR_SIZE_16;
					len_n   = '0;
					phase_n = wsfd_pkg::PH_EXT;
				end else if (len7 == wsfd_pkg::LEN_CODE64) begin
					hdr_n   = wsfd_pkg::HDR_SIZE_64;
					len_n   = '0;
					phase_n = wsfd_pkg::PH_EXT;
				end else begin
					hdr_n    = wsfd_pkg::HDR_SIZE_BASE;
					len_n    = {{(wsfd_pkg::LEN_W-7){1'b0}}, len7};
					len_done = 1'b1;
				end
			end
			wsfd_pkg::PH_EXT: begin
				part  = wsfd_pkg::PART_EXT;
				len_n = {len_q[wsfd_pkg::LEN_W-wsfd_pkg::BYTE_W-1:0], data_in};
				idx_n = idx_q + 4'd1;
				if ({1'b0, idx_n} + 5'd2 >= {1'b0, hdr_q})
					len_done = 1'b1;
			end
			wsfd_pkg::PH_MASK: begin
				part  = wsfd_pkg::PART_MASK;
				idx_n = idx_q + 4'd1;
				if (idx_n >= wsfd_pkg::KEY_BYTES)
					pay_or_end = 1'b1;
			end
			default: begin
				part     = wsfd_pkg::PART_PAYLOAD;
				rem_dec  = (remain_q != '0) ? remain_q - 64'd1 : remain_q;
				remain_n = rem_dec;
				if (rem_dec == '0)
					end_c = 1'b1;
			end
		endcase

		fixed   = {1'b0, hdr_n} + (masked_n ? {1'b0, wsfd_pkg::KEY_BYTES} : 5'd0);
		sum     = {1'b0, len_n} + {{(wsfd_pkg::LEN_W-wsfd_pkg::HDR_W){1'b0}}, fixed};
		total_c = sum[wsfd_pkg::LEN_W] ? {wsfd_pkg::LEN_W{1'b1}} : sum[wsfd_pkg::LEN_W-1:0];

		if (len_done) begin
			total_n = total_c;
			if (sum[wsfd_pkg::LEN_W] || (total_c > size_limit))
				err_n = 1'b1;
			if (masked_n) begin
				idx_n   = '0;
				phase_n = wsfd_pkg::PH_MASK;
			end else begin
				pay_or_end = 1'b1;
			end
		end

		if (pay_or_end) begin
			if (len_n != '0) begin
				remain_n = len_n;
				phase_n  = wsfd_pkg::PH_PAYLOAD;
			end else begin
				end_c = 1'b1;
			end
		end

		if (end_c) begin
			phase_n  = wsfd_pkg::PH_HDR0;
			idx_n    = '0;
			remain_n = '0;
		end

		res.part      = part;
		res.frame_end = end_c;
		res.oversize  = err_n;
		res.total     = end_c ? total_n : '0;
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("oversize error cleared without reset");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsfd_pkg::PH_PAYLOAD) |-> (remain_q != '0))
		else $error("payload phase with zero bytes remaining");

	a_mask_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsfd_pkg::PH_MASK) |-> (masked_q && (idx_q < wsfd_pkg::KEY_BYTES)))
		else $error("mask key phase without mask bit or past key end");

endmodule

@@ rtl/core/websocket_frame_delimiter_top.sv @@
// Channel  Handshake               Payload
// in       in_valid / in_ready     data_byte
// out      out_valid / out_ready   out_byte, frame_part, frame_end, oversize_error,
//                                  frame_total
// cfg      cfg_wr_en               cfg_wr_data (frame size limit)
//
// One request per cycle sustained while out_ready stays high. The byte is held in an input
// register, parsed in one combinational pass, and the result lands in the output register,
// which raises out_valid; the parse pass sets the rate.
// Reset clears the parse state, the sticky error and both valid flags, and loads the
// frame size limit with 65536.
// A stalled output still takes a new request: the input register fills behind it.
module websocket_frame_delimiter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [wsfd_pkg::BYTE_W-1:0]    data_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [wsfd_pkg::BYTE_W-1:0]    out_byte,
	output logic [1:0]                     frame_part,
	output logic                           frame_end,
	output logic                           oversize_error,
	output logic [wsfd_pkg::LEN_W-1:0]     frame_total,
	input  logic                           cfg_wr_en,
	input  logic [wsfd_pkg::LEN_W-1:0]     cfg_wr_data
);

	logic [wsfd_pkg::LEN_W-1:0]  max_q;
	logic                        valid_s1;
	logic [wsfd_pkg::BYTE_W-1:0] byte_s1;
	logic                        valid_s2;
	logic [wsfd_pkg::BYTE_W-1:0] byte_s2;
	wsfd_pkg::res_t              res_s2;
	wsfd_pkg::res_t              res_c;
	logic                        advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_q <= wsfd_pkg::MAX_FRAME_RESET;
		else if (cfg_wr_en)
			max_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= data_byte;
		if (advance) begin
			byte_s2 <= byte_s1;
			res_s2  <= res_c;
		end
	end

	wsfd_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.data_in         (byte_s1),
		.size_limit      (max_q),
		.res             (res_c)
	);

	assign out_valid      = valid_s2;
	assign out_byte       = byte_s2;
	assign frame_part     = res_s2.part;
	assign frame_end      = res_s2.frame_end;
	assign oversize_error = res_s2.oversize;
	assign frame_total    = res_s2.total;

	a_total_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.frame_end) |-> (res_s2.total == '0))
		else $error("frame total shown on a byte that does not end a frame");

	a_advance_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("parsed request lost between stages");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(byte_s2)))
		else $error("stalled result dropped or changed");

endmodule

@@ test/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {
		LEN_DIRECT,
		LEN_EXT16,
		LEN_EXT64
	} len_form_t;

	typedef struct {
		logic [wsfd_pkg::BYTE_W-1:0] data;
		wsfd_pkg::part_t             part;
		logic                        last;
		logic                        oversize;
		logic [wsfd_pkg::LEN_W-1:0]  total;
	} byte_tag_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [wsfd_pkg::BYTE_W-1:0] data_byte = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [wsfd_pkg::BYTE_W-1:0] out_byte;
	logic [1:0]                  frame_part;
	logic                        frame_end;
	logic                        oversize_error;
	logic [wsfd_pkg::LEN_W-1:0]  frame_total;
	logic                        cfg_wr_en = 1'b0;
	logic [wsfd_pkg::LEN_W-1:0]  cfg_wr_data = '0;

	websocket_frame_delimiter_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.frame_part    (frame_part),
		.frame_end     (frame_end),
		.oversize_error(oversize_error),
		.frame_total   (frame_total),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always #2 clk = ~clk;

	// Parser state mirrored for prediction
	wsfd_pkg::phase_t           parse_at;
	logic [wsfd_pkg::IDX_W-1:0] ext_count;
	logic                       has_mask;
	logic [wsfd_pkg::LEN_W-1:0] length_field;
	logic [wsfd_pkg::LEN_W-1:0] bytes_left;
	logic [wsfd_pkg::HDR_W-1:0] head_bytes;
	logic                       too_big;
	logic [wsfd_pkg::LEN_W-1:0] frame_limit;

	logic [wsfd_pkg::BYTE_W-1:0] wire_bytes[$];
	byte_tag_t                   byte_tags[$];

	bit in_taken = 1'b0;
	bit hold_off_arm = 1'b0;
	bit hold_off_done = 1'b0;
	int hold_left = 0;
	int burst_left = 0;
	int gap_left = 0;
	int seg_left = 0;
	int seg_mode = 0;
	int rx_tick = 0;
	int fail_count = 0;
	int bytes_checked = 0;
	int frames_closed = 0;
	bit error_seen = 1'b0;

	function automatic logic [wsfd_pkg::LEN_W-1:0] frame_bytes(output logic wrapped);
		logic [wsfd_pkg::LEN_W-1:0] fixed;
		fixed = wsfd_pkg::LEN_W'(head_bytes)
			+ (has_mask ? wsfd_pkg::LEN_W'(wsfd_pkg::KEY_BYTES) : '0);
		wrapped = length_field > (~64'd0 - fixed);
		return wrapped ? ~64'd0 : length_field + fixed;
	endfunction

	task automatic enter_payload(output logic closes);
		closes = 1'b0;
		if (length_field != 0) begin
			bytes_left = length_field;
			parse_at = wsfd_pkg::PH_PAYLOAD;
		end else begin
			closes = 1'b1;
		end
	endtask

	task automatic length_known(output logic closes);
		logic                       wrapped;
		logic [wsfd_pkg::LEN_W-1:0] sum;
		sum = frame_bytes(wrapped);
		if (wrapped || sum > frame_limit)
			too_big = 1'b1;
		closes = 1'b0;
		if (has_mask) begin
			ext_count = '0;
			parse_at = wsfd_pkg::PH_MASK;
		end else begin
			enter_payload(closes);
		end
	endtask

	task automatic delimit_byte(input logic [wsfd_pkg::BYTE_W-1:0] b, output byte_tag_t tag);
		logic       closes;
		logic       wrapped;
		logic [6:0] len7;
		closes = 1'b0;
		tag.data = b;
		tag.part = wsfd_pkg::PART_HDR;
		tag.total = '0;
		case (parse_at)
			wsfd_pkg::PH_HDR0: parse_at = wsfd_pkg::PH_HDR1;
			wsfd_pkg::PH_HDR1: begin
				len7 = b[6:0] & wsfd_pkg::LEN7_MASK;
				has_mask = b[wsfd_pkg::MASK_BIT];
				ext_count = '0;
				if (len7 == wsfd_pkg::LEN_CODE16) begin
					head_bytes = wsfd_pkg::HDR_SIZE_16;
					length_field = '0;
					parse_at = wsfd_pkg::PH_EXT;
				end else if (len7 == wsfd_pkg::LEN_CODE64) begin
					head_bytes = wsfd_pkg::HDR_SIZE_64;
					length_field = '0;
					parse_at = wsfd_pkg::PH_EXT;
				end else begin
					head_bytes = wsfd_pkg::HDR_SIZE_BASE;
					length_field = wsfd_pkg::LEN_W'(len7);
					length_known(closes);
				end
			end
			wsfd_pkg::PH_EXT: begin
				tag.part = wsfd_pkg::PART_EXT;
				length_field = {length_field[wsfd_pkg::LEN_W-9:0], b};
				ext_count = ext_count + 4'd1;
				if (int'(ext_count) + 2 >= int'(head_bytes))
					length_known(closes);
			end
			wsfd_pkg::PH_MASK: begin
				tag.part = wsfd_pkg::PART_MASK;
				ext_count = ext_count + 4'd1;
				if (ext_count >= wsfd_pkg::KEY_BYTES)
					enter_payload(closes);
			end
			default: begin
				tag.part = wsfd_pkg::PART_PAYLOAD;
				if (bytes_left != 0)
					bytes_left = bytes_left - 64'd1;
				if (bytes_left == 0)
					closes = 1'b1;
			end
		endcase
		if (closes) begin
			tag.total = frame_bytes(wrapped);
			parse_at = wsfd_pkg::PH_HDR0;
			ext_count = '0;
			bytes_left = '0;
		end
		tag.last = closes;
		tag.oversize = too_big;
	endtask

	task automatic check_field(input string name, input logic [wsfd_pkg::LEN_W-1:0] want,
		input logic [wsfd_pkg::LEN_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic add_byte(input logic [wsfd_pkg::BYTE_W-1:0] b);
		wire_bytes.insert(wire_bytes.size(), b);
	endtask

	task automatic push_frame(input logic [wsfd_pkg::BYTE_W-1:0] first, input logic masked,
		input len_form_t form, input logic [wsfd_pkg::LEN_W-1:0] len, input int count);
		logic [6:0] code;
		code = (form == LEN_EXT16) ? wsfd_pkg::LEN_CODE16
			: (form == LEN_EXT64) ? wsfd_pkg::LEN_CODE64 : len[6:0];
		add_byte(first);
		add_byte({masked, code});
		if (form == LEN_EXT16)
			for (int i = 1; i >= 0; i--)
				add_byte(len[8*i +: 8]);
		if (form == LEN_EXT64)
			for (int i = 7; i >= 0; i--)
				add_byte(len[8*i +: 8]);
		if (masked)
			repeat (wsfd_pkg::KEY_BYTES) add_byte(8'($urandom));
		repeat (count) add_byte(8'($urandom));
	endtask

	task automatic queue_random(input int count);
		int                         start;
		int                         pick;
		logic                       masked;
		len_form_t                  form;
		logic [wsfd_pkg::LEN_W-1:0] len;
		start = wire_bytes.size();
		while (wire_bytes.size() - start < count) begin
			masked = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				form = LEN_DIRECT;
				len = wsfd_pkg::LEN_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 15)
					: $urandom_range(0, 125));
			end else if (pick < 85) begin
				form = LEN_EXT16;
				len = wsfd_pkg::LEN_W'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 40)
					: $urandom_range(126, 300));
			end else begin
				form = LEN_EXT64;
				len = wsfd_pkg::LEN_W'(($urandom_range(0, 7) != 0) ? $urandom_range(0, 20)
					: $urandom_range(256, 400));
			end
			push_frame(8'($urandom), masked, form, len, int'(len));
		end
	endtask

	task automatic load_limit(input logic [wsfd_pkg::LEN_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		frame_limit = value;
		@(posedge clk);
	endtask

	task automatic drain();
		do begin
			@(negedge clk);
			#1;
		end while (wire_bytes.size() != 0 || in_valid || byte_tags.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (wire_bytes.size() != 0) begin
				data_byte <= wire_bytes.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : rx_pace
		logic rdy;
		if (hold_off_arm && !hold_off_done) begin
			hold_left = 200;
			hold_off_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			rdy = 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(1, 40);
				seg_mode = $urandom_range(0, 3);
			end
			seg_left--;
			rx_tick++;
			case (seg_mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = (rx_tick % 3) != 0;
				default: rdy = ($urandom_range(0, 7) == 0);
			endcase
		end
		out_ready <= rdy;
	end

	always @(posedge clk) begin : watch
		byte_tag_t want;
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			delimit_byte(data_byte, want);
			byte_tags.insert(byte_tags.size(), want);
		end
		if (arst_n && out_valid && out_ready) begin
			if (byte_tags.size() == 0) begin
				$error("out_byte: no request pending, got 0x%0h", out_byte);
				fail_count++;
			end else begin
				want = byte_tags.pop_front();
				check_field("out_byte", wsfd_pkg::LEN_W'(want.data),
					wsfd_pkg::LEN_W'(out_byte));
				check_field("frame_part", wsfd_pkg::LEN_W'(want.part),
					wsfd_pkg::LEN_W'(frame_part));
				check_field("frame_end", wsfd_pkg::LEN_W'(want.last),
					wsfd_pkg::LEN_W'(frame_end));
				check_field("oversize_error", wsfd_pkg::LEN_W'(want.oversize),
					wsfd_pkg::LEN_W'(oversize_error));
				check_field("frame_total", want.total, frame_total);
				bytes_checked++;
				if (want.last)
					frames_closed++;
				if (want.oversize)
					error_seen = 1'b1;
			end
		end
	end

	initial begin
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		parse_at = wsfd_pkg::PH_HDR0;
		ext_count = '0;
		has_mask = 1'b0;
		length_field = '0;
		bytes_left = '0;
		head_bytes = '0;
		too_big = 1'b0;
		frame_limit = wsfd_pkg::MAX_FRAME_RESET;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		push_frame(8'h00, 1'b0, LEN_DIRECT, 64'd0, 0);
		push_frame(8'hff, 1'b1, LEN_DIRECT, 64'd0, 0);
		push_frame(8'h81, 1'b0, LEN_EXT16, 64'd0, 0);
		push_frame(8'h82, 1'b0, LEN_EXT64, 64'd1, 1);
		drain();

		load_limit(~64'd0);
		queue_random(600);
		hold_off_arm = 1'b1;
		drain();

		// total equal to the limit passes, one byte more latches the error
		load_limit(64'd10);
		push_frame(8'h02, 1'b0, LEN_DIRECT, 64'd8, 8);
		push_frame(8'h02, 1'b0, LEN_DIRECT, 64'd9, 9);
		drain();

		load_limit(64'd1);
		queue_random(400);
		drain();

		load_limit(64'd0);
		push_frame(8'h89, 1'b0, LEN_DIRECT, 64'd0, 0);
		push_frame(8'h8a, 1'b1, LEN_EXT16, 64'd3, 3);
		drain();

		load_limit({32'($urandom), 32'($urandom)});
		queue_random(400);
		drain();

		// size that wraps 64 bits: payload never ends, so this goes last
		push_frame(8'hff, 1'b1, LEN_EXT64, ~64'd0, 6);
		drain();
		repeat (8) @(negedge clk);

		$display("Covered %0d bytes and %0d complete frames over limits 0, 1, 10, 65536,",
			bytes_checked, frames_closed);
		$display("all ones and one random value; sticky oversize flag reached: %0d.", error_seen);
		if (fail_count == 0 && byte_tags.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
